/* sv/cbpt_pkg.sv */
// ----------------------------------------------------------------------------
// cbpt_pkg
// shared types, widths and constants of the covalent bond pair test block
// ----------------------------------------------------------------------------
package cbpt_pkg;

    // field widths
    localparam int unsigned IdxW   = 16;
    localparam int unsigned CoordW = 24;
    localparam int unsigned RadW   = 14;
    localparam int unsigned ImgW   = 8;
    localparam int unsigned LatW   = 21;
    localparam int unsigned VecW   = 3 * LatW;
    localparam int unsigned ScaleW = 16;

    // arithmetic widths
    localparam int unsigned DposW  = CoordW + 1;
    localparam int unsigned ProdW  = ImgW + LatW;
    localparam int unsigned DispW  = 30;
    localparam int unsigned SqW    = 2 * DispW - 2;
    localparam int unsigned D2W    = SqW + 2;
    localparam int unsigned RsumW  = RadW + 1;
    localparam int unsigned TW     = RsumW + ScaleW;
    localparam int unsigned TtW    = 2 * TW;
    localparam int unsigned FracShift = 24;
    localparam int unsigned D2LimW    = TtW - FracShift;

    // limits
    localparam int unsigned MaxAtoms   = 65536;
    localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(4096);
    // 0.4^2 in Q.24, rounded down
    localparam logic [D2W-1:0] MinD2Q24 = D2W'(2684354);

    // queues and pipeline
    localparam int unsigned MidDepth  = 4;
    localparam int unsigned MidPtrW   = $clog2(MidDepth);
    localparam int unsigned MidCntW   = $clog2(MidDepth + 1);
    localparam int unsigned OutDepth  = 8;
    localparam int unsigned OutPtrW   = $clog2(OutDepth);
    localparam int unsigned OutCntW   = $clog2(OutDepth + 1);
    localparam int unsigned PipeDepth = 4;
    localparam int unsigned PipeCntW  = $clog2(PipeDepth + 1);

    // configuration register indexes
    localparam int unsigned CfgIdxW = 2;
    typedef enum logic [CfgIdxW-1:0] {
        CFG_LAT_A,
        CFG_LAT_B,
        CFG_LAT_C,
        CFG_BOND_SCALE
    } t_cfg_reg;

    typedef enum logic {
        OP_CENTER,
        OP_NEIGHBOR
    } t_opcode;

    typedef struct packed {
        t_opcode                 opcode;
        logic [IdxW-1:0]         atom_index;
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] pos_z;
        logic [RadW-1:0]         radius;
        logic                    has_radius;
        logic signed [ImgW-1:0]  image_x;
        logic signed [ImgW-1:0]  image_y;
        logic signed [ImgW-1:0]  image_z;
    } t_in_item;

    typedef struct packed {
        logic [IdxW-1:0]        first_atom;
        logic [IdxW-1:0]        second_atom;
        logic signed [ImgW-1:0] bond_image_x;
        logic signed [ImgW-1:0] bond_image_y;
        logic signed [ImgW-1:0] bond_image_z;
    } t_out_item;

    // one classified neighbor pair on its way to the back end
    typedef struct packed {
        t_out_item               res;
        logic [2:0][DposW-1:0]   dpos;
        logic [RsumW-1:0]        rsum;
    } t_job;

    typedef struct packed {
        logic [VecW-1:0]   lat_a;
        logic [VecW-1:0]   lat_b;
        logic [VecW-1:0]   lat_c;
        logic [ScaleW-1:0] scale;
    } t_cfg;

    // component k (x, y, z) of a packed lattice vector
    function automatic logic signed [LatW-1:0] lat_comp(
        input logic [VecW-1:0] vec,
        input int unsigned     k
    );
        return vec[LatW*k +: LatW];
    endfunction

endpackage

/* sv/cbpt_front.sv */
// ----------------------------------------------------------------------------
// cbpt_front
// accepts items, latches the center atom and classifies neighbor pairs
// ----------------------------------------------------------------------------
module cbpt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cbpt_pkg::t_in_item i_item,
    input  logic             i_push,
    input  logic             i_q_full,
    output logic             o_job_we,
    output cbpt_pkg::t_job   o_job
);
    import cbpt_pkg::*;

    logic                    r_center_usable;
    logic [IdxW-1:0]         r_center_atom;
    logic [2:0][CoordW-1:0]  r_center_pos;
    logic [RadW-1:0]         r_center_radius;

    logic                    w_accept;
    logic                    w_center_we;
    logic [2:0][CoordW-1:0]  w_pos;
    logic                    w_idx_ok;

    assign w_accept    = i_push && !i_q_full;
    assign w_center_we = w_accept && (i_item.opcode == OP_CENTER);
    assign w_idx_ok    = 32'(i_item.atom_index) < MaxAtoms;
    assign w_pos       = {i_item.pos_z, i_item.pos_y, i_item.pos_x};

    // center usable flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_usable <= 1'b0;
        end else if (w_center_we) begin
            r_center_usable <= i_item.has_radius && w_idx_ok;
        end
    end

    // center payload
    always_ff @(posedge i_clk) begin
        if (w_center_we) begin
            r_center_atom   <= i_item.atom_index;
            r_center_pos    <= w_pos;
            r_center_radius <= i_item.radius;
        end
    end

    // neighbor filter: only pairs that may bond go to the back end
    assign o_job_we = w_accept && (i_item.opcode == OP_NEIGHBOR) && r_center_usable
                   && i_item.has_radius && w_idx_ok
                   && (i_item.atom_index > r_center_atom);

    // pair payload: raw displacement and summed radii
    always_comb begin
        o_job.res.first_atom   = r_center_atom;
        o_job.res.second_atom  = i_item.atom_index;
        o_job.res.bond_image_x = i_item.image_x;
        o_job.res.bond_image_y = i_item.image_y;
        o_job.res.bond_image_z = i_item.image_z;
        for (int k = 0; k < 3; k++) begin
            o_job.dpos[k] = {w_pos[k][CoordW-1], w_pos[k]}
                          - {r_center_pos[k][CoordW-1], r_center_pos[k]};
        end
        o_job.rsum = {1'b0, i_item.radius} + {1'b0, r_center_radius};
    end

endmodule

/* sv/cbpt_mid_q.sv */
// ----------------------------------------------------------------------------
// cbpt_mid_q
// short queue of classified pairs between the front and the back end
// ----------------------------------------------------------------------------
module cbpt_mid_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_we,
    input  cbpt_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_re,
    output logic           o_empty,
    output cbpt_pkg::t_job o_job
);
    import cbpt_pkg::*;

    t_job               r_mem [MidDepth];
    logic [MidPtrW-1:0] r_wr_ptr;
    logic [MidPtrW-1:0] r_rd_ptr;
    logic [MidCntW-1:0] r_cnt;

    logic w_wr;
    logic w_rd;

    assign o_full  = r_cnt == MidCntW'(MidDepth);
    assign o_empty = r_cnt == '0;
    assign w_wr    = i_we && !o_full;
    assign w_rd    = i_re && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + MidCntW'(w_wr) - MidCntW'(w_rd);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* sv/cbpt_back.sv */
// ----------------------------------------------------------------------------
// cbpt_back
// four-stage distance test pipeline with credit-checked result queue
// ----------------------------------------------------------------------------
module cbpt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cbpt_pkg::t_cfg    i_cfg,
    input  logic              i_q_empty,
    input  cbpt_pkg::t_job    i_job,
    output logic              o_q_re,
    input  logic              i_pop,
    output logic              o_empty,
    output cbpt_pkg::t_out_item o_result
);
    import cbpt_pkg::*;

    // stage valids
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;

    // stage payloads
    t_job                         r_s1_job;
    t_out_item                    r_s2_res, r_s3_res, r_s4_res;
    logic signed [DispW-1:0]      r_s2_d [3];
    logic [TW-1:0]                r_s2_t;
    logic [SqW-1:0]               r_s3_sq [3];
    logic [TtW-1:0]               r_s3_tt;
    logic [D2W-1:0]               r_s4_d2;
    logic [TtW-1:0]               r_s4_tt;

    // result queue
    t_out_item                    r_out_mem [OutDepth];
    logic [OutPtrW-1:0]           r_out_wr_ptr;
    logic [OutPtrW-1:0]           r_out_rd_ptr;
    logic [OutCntW-1:0]           r_out_cnt;

    logic [PipeCntW-1:0]          w_inflight;
    logic                         w_out_we;
    logic                         w_out_rd;
    logic signed [DispW-1:0]      w_d [3];
    logic signed [2*DispW-1:0]    w_prod [3];
    logic                         w_bond;

    // issue only with room reserved in the result queue
    assign w_inflight = PipeCntW'(r_s1_vld) + PipeCntW'(r_s2_vld)
                      + PipeCntW'(r_s3_vld) + PipeCntW'(r_s4_vld);
    assign o_q_re = !i_q_empty
                 && ((OutCntW + 1)'(r_out_cnt) + (OutCntW + 1)'(w_inflight)
                     < (OutCntW + 1)'(OutDepth));

    // stage 1 math: displacement plus image shifts
    always_comb begin
        logic signed [ProdW-1:0] pa, pb, pc;
        for (int k = 0; k < 3; k++) begin
            pa = r_s1_job.res.bond_image_x * lat_comp(i_cfg.lat_a, k);
            pb = r_s1_job.res.bond_image_y * lat_comp(i_cfg.lat_b, k);
            pc = r_s1_job.res.bond_image_z * lat_comp(i_cfg.lat_c, k);
            w_d[k] = DispW'($signed(r_s1_job.dpos[k])) + DispW'(pa) + DispW'(pb)
                   + DispW'(pc);
        end
    end

    // stage 2 math: squares
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_prod[k] = r_s2_d[k] * r_s2_d[k];
        end
    end

    // stage 4 math: window test on squared distance
    assign w_bond = (r_s4_d2 > MinD2Q24)
                 && (r_s4_d2[D2W-1:D2LimW] == '0)
                 && ({r_s4_d2[D2LimW-1:0], FracShift'(0)} < r_s4_tt);
    assign w_out_we = r_s4_vld && w_bond;

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= o_q_re;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_job <= i_job;
        r_s2_res <= r_s1_job.res;
        for (int k = 0; k < 3; k++) begin
            r_s2_d[k]  <= w_d[k];
            r_s3_sq[k] <= w_prod[k][SqW-1:0];
        end
        r_s2_t   <= r_s1_job.rsum * i_cfg.scale;
        r_s3_res <= r_s2_res;
        r_s3_tt  <= r_s2_t * r_s2_t;
        r_s4_res <= r_s3_res;
        r_s4_d2  <= {2'b00, r_s3_sq[0]} + {2'b00, r_s3_sq[1]} + {2'b00, r_s3_sq[2]};
        r_s4_tt  <= r_s3_tt;
    end

    // result queue control
    assign o_empty  = r_out_cnt == '0;
    assign w_out_rd = i_pop && !o_empty;
    assign o_result = r_out_mem[r_out_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr_ptr <= '0;
            r_out_rd_ptr <= '0;
            r_out_cnt    <= '0;
        end else begin
            if (w_out_we) begin
                r_out_wr_ptr <= r_out_wr_ptr + 1'b1;
            end
            if (w_out_rd) begin
                r_out_rd_ptr <= r_out_rd_ptr + 1'b1;
            end
            r_out_cnt <= r_out_cnt + OutCntW'(w_out_we) - OutCntW'(w_out_rd);
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (w_out_we) begin
            r_out_mem[r_out_wr_ptr] <= r_s4_res;
        end
    end

`ifndef SYNTHESIS
    // reserved room never exceeds the queue
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_out_cnt) + 32'(w_inflight)) <= OutDepth)
        else $error("result queue overcommitted");

    // a written result never lands in a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_we |-> (r_out_cnt != OutCntW'(OutDepth)))
        else $error("result queue overflow");

    // every bond pairs a neighbor above its center
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_we |-> (r_s4_res.second_atom > r_s4_res.first_atom))
        else $error("bond with neighbor not above center");

    // a pair in stage 1 reaches stage 4 by way of stages 2 and 3
    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |=> ##2 r_s4_vld)
        else $error("pipeline lost a pair");
`endif

endmodule

/* sv/covalent_bond_pair_test_top.sv */
// ----------------------------------------------------------------------------
// covalent_bond_pair_test_top
// covalent radius bond detection over a stream of center and neighbor items
// ----------------------------------------------------------------------------
// A center item latches the atom index, position and radius in the front end
// in the cycle it is taken; each neighbor item is filtered there and, if it
// can bond, goes through a four-entry queue into a four-stage back end
// (lattice image shift, squares, sum, window test). One item is taken every
// cycle while full is low. A bond goes from the window test stage into the
// result queue. The back end issues only while the eight-entry result queue
// has room for everything in flight, so with pop held high the block keeps
// one item per cycle; a stalled result side fills the middle queue and then
// raises full.
// ----------------------------------------------------------------------------
module covalent_bond_pair_test_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input queue side
    input  logic                         push,
    output logic                         full,
    input  cbpt_pkg::t_in_item           i_item,
    // result queue side
    output logic                         empty,
    input  logic                         pop,
    output cbpt_pkg::t_out_item          o_result,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [cbpt_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [cbpt_pkg::VecW-1:0]    i_cfg_data
);
    import cbpt_pkg::*;

    t_cfg r_cfg;
    t_job w_front_job;
    t_job w_back_job;
    logic w_front_we;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_re;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lat_a <= '0;
            r_cfg.lat_b <= '0;
            r_cfg.lat_c <= '0;
            r_cfg.scale <= ScaleReset;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_LAT_A:      r_cfg.lat_a <= i_cfg_data;
                CFG_LAT_B:      r_cfg.lat_b <= i_cfg_data;
                CFG_LAT_C:      r_cfg.lat_c <= i_cfg_data;
                CFG_BOND_SCALE: r_cfg.scale <= i_cfg_data[ScaleW-1:0];
            endcase
        end
    end

    assign full = w_q_full;

    // front end
    cbpt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_push   (push),
        .i_q_full (w_q_full),
        .o_job_we (w_front_we),
        .o_job    (w_front_job)
    );

    // pair queue
    cbpt_mid_q u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_front_we),
        .i_job   (w_front_job),
        .o_full  (w_q_full),
        .i_re    (w_q_re),
        .o_empty (w_q_empty),
        .o_job   (w_back_job)
    );

    // back end
    cbpt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_q_empty),
        .i_job     (w_back_job),
        .o_q_re    (w_q_re),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule
